// ===== sv/art_pkg.sv =====
`default_nettype none

package art_pkg;

	localparam int TABLE_LEN  = 24;
	localparam int ATAN_W     = 22;
	localparam int ANGLE_W    = 24;
	localparam int VEC_W      = 27;
	localparam int SAMPLE_W   = 16;
	localparam int WIDE_W     = 17;
	localparam int PRESCALE   = 8;
	localparam int FRAC_DROP  = 8;
	localparam int ROUND_HALF = 128;
	localparam int HALF_TURN  = 23040;
	localparam int THRESH_W   = 15;

	// Arctangent of 2^-i in degrees scaled by 2^15, rounded.
	localparam logic [ATAN_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
		22'd1474560, 22'd870484, 22'd459940, 22'd233473,
		22'd117189,  22'd58652,  22'd29333,  22'd14667,
		22'd7334,    22'd3667,   22'd1833,   22'd917,
		22'd458,     22'd229,    22'd115,    22'd57,
		22'd29,      22'd14,     22'd7,      22'd4,
		22'd2,       22'd1,      22'd0,      22'd0
	};

	typedef enum logic [1:0] {
		BASE_ZERO = 2'b00,
		BASE_POS  = 2'b01,
		BASE_NEG  = 2'b10
	} base_t;

	typedef struct packed {
		logic                       y_zero;
		base_t                      base;
		logic signed [VEC_W-1:0]    x;
		logic signed [VEC_W-1:0]    y;
		logic signed [ANGLE_W-1:0]  acc;
	} cordic_t;

endpackage

`default_nettype wire

// ===== sv/art_cordic_stage.sv =====
`default_nettype none

module art_cordic_stage #(
	parameter int unsigned SHIFT = 0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  wire               in_valid,
	input  wire art_pkg::cordic_t in_data,
	output logic              out_valid,
	output art_pkg::cordic_t  out_data
);
	import art_pkg::*;

	logic signed [ANGLE_W-1:0] step;
	logic signed [VEC_W-1:0]   xs;
	logic signed [VEC_W-1:0]   ys;
	cordic_t                   nxt;
	cordic_t                   data_s1;
	logic                      valid_s1;

	assign step = signed'(ANGLE_W'(ATAN_TABLE[SHIFT]));
	assign xs   = in_data.x >>> SHIFT;
	assign ys   = in_data.y >>> SHIFT;

	always_comb begin
		nxt = in_data;
		if (!in_data.y[VEC_W-1]) begin
			nxt.x   = in_data.x + ys;
			nxt.y   = in_data.y - xs;
			nxt.acc = in_data.acc + step;
		end else begin
			nxt.x   = in_data.x - ys;
			nxt.y   = in_data.y + xs;
			nxt.acc = in_data.acc - step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

// ===== sv/accel_roll_tilt_alert_unit.sv =====
// Roll angle atan2(y, z) in 1/128 degree with a tilt alert flag.
// The pipeline has one register per CORDIC micro-rotation (iterations capped at 24)
// plus prepare, round and output registers, the first loaded at the accepting edge.
// Throughput: one transaction per cycle; each stage holds its item on a stall.
// Reset (arst_n low, asynchronous): pipeline empties, threshold returns to 5760.
`default_nettype none

module accel_roll_tilt_alert_unit #(
	parameter int ANGLE_ITERATIONS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [14:0] cfg_data,      // alert_threshold
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // accel_y [15:0], accel_z [31:16]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,  // roll_deg [15:0]
	output logic [0:0]  m_axis_tuser   // tilt_alert [0]
);
	import art_pkg::*;

	localparam int NITER = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN : ANGLE_ITERATIONS;

	logic [THRESH_W-1:0] thr_q;

	logic signed [WIDE_W-1:0] y_in;
	logic signed [WIDE_W-1:0] z_in;
	logic signed [WIDE_W-1:0] y_rot;
	logic signed [WIDE_W-1:0] z_rot;
	cordic_t                  prep;

	logic    v_s1;
	cordic_t d_s1;

	wire          [NITER:0] v_c;
	wire cordic_t           d_c [0:NITER];
	logic         [NITER:0] en_c;

	logic                       en_o;
	logic                       en_s2;
	logic signed [ANGLE_W-1:0]  rnd_full;
	logic signed [WIDE_W-1:0]   base_val;
	logic signed [WIDE_W-1:0]   ang_nxt;
	logic                       v_s2;
	logic signed [WIDE_W-1:0]   ang_s2;

	logic signed [SAMPLE_W-1:0] sat;
	logic        [SAMPLE_W-1:0] mag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_W'(5760);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Fold the left half plane onto the right one and prescale the samples.
	always_comb begin
		y_in  = {s_axis_tdata[15], s_axis_tdata[15:0]};
		z_in  = {s_axis_tdata[31], s_axis_tdata[31:16]};
		y_rot = y_in;
		z_rot = z_in;
		prep  = '0;
		prep.base = BASE_ZERO;
		if (z_in[WIDE_W-1]) begin
			y_rot = -y_in;
			z_rot = -z_in;
			prep.base = y_in[WIDE_W-1] ? BASE_NEG : BASE_POS;
		end
		prep.y_zero = (y_in == '0);
		prep.x      = {{(VEC_W-WIDE_W-PRESCALE){z_rot[WIDE_W-1]}}, z_rot, PRESCALE'(0)};
		prep.y      = {{(VEC_W-WIDE_W-PRESCALE){y_rot[WIDE_W-1]}}, y_rot, PRESCALE'(0)};
		prep.acc    = '0;
	end

	always_comb begin
		en_o         = !m_axis_tvalid || m_axis_tready;
		en_s2        = !v_s2 || en_o;
		en_c[NITER]  = !v_c[NITER] || en_s2;
		for (int k = NITER - 1; k >= 0; k--) begin
			en_c[k] = !v_c[k] || en_c[k+1];
		end
	end

	assign s_axis_tready = en_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_c[0]) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_c[0] && s_axis_tvalid) begin
			d_s1 <= prep;
		end
	end

	assign v_c[0] = v_s1;
	assign d_c[0] = d_s1;

	for (genvar j = 0; j < NITER; j++) begin : g_rot
		art_cordic_stage #(
			.SHIFT (j)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en_c[j+1]),
			.in_valid  (v_c[j]),
			.in_data   (d_c[j]),
			.out_valid (v_c[j+1]),
			.out_data  (d_c[j+1])
		);
	end

	always_comb begin
		rnd_full = (d_c[NITER].acc + ANGLE_W'(ROUND_HALF)) >>> FRAC_DROP;
		case (d_c[NITER].base)
			BASE_POS: base_val = WIDE_W'(HALF_TURN);
			BASE_NEG: base_val = -WIDE_W'(HALF_TURN);
			default:  base_val = '0;
		endcase
		if (d_c[NITER].y_zero) begin
			ang_nxt = base_val;
		end else begin
			ang_nxt = WIDE_W'(rnd_full) + base_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_c[NITER];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_c[NITER]) begin
			ang_s2 <= ang_nxt;
		end
	end

	always_comb begin
		if (ang_s2 > WIDE_W'(HALF_TURN)) begin
			sat = SAMPLE_W'(HALF_TURN);
		end else if (ang_s2 < -WIDE_W'(HALF_TURN)) begin
			sat = -SAMPLE_W'(HALF_TURN);
		end else begin
			sat = SAMPLE_W'(ang_s2);
		end
		mag = sat[SAMPLE_W-1] ? SAMPLE_W'(-sat) : SAMPLE_W'(sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en_o) begin
			m_axis_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s2) begin
			m_axis_tdata <= sat;
			m_axis_tuser <= (mag > {1'b0, thr_q});
		end
	end

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) <= HALF_TURN
			&& $signed(m_axis_tdata) >= -HALF_TURN))
		else $error("roll angle out of range");

	a_alert_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata != '0))
		else $error("alert raised for a zero angle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register is empty");

endmodule

`default_nettype wire

// ===== tb/accel_roll_tilt_alert_unit_tb.sv =====
`timescale 1ns / 1ps

typedef struct {
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] angle;
	logic               alert;
} roll_want_t;

class roll_scoreboard;
	localparam int HALF_TURN = 23040;
	localparam int TABLE_LEN = 24;

	int iterations;
	logic [14:0] threshold;
	roll_want_t want_q[$];
	int mismatches;
	int checked;
	int alerts_seen;
	int samples;
	longint atan_q15 [TABLE_LEN] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	function new(int iters);
		iterations = iters;
		threshold = 15'd5760;
	endfunction

	function logic signed [15:0] predict_roll(logic signed [15:0] ay, logic signed [15:0] az);
		longint x, y, acc, ang, xs, ys, base;
		int n;
		logic signed [15:0] r;
		y = ay;
		x = az;
		acc = 0;
		base = 0;
		if (y == 0) begin
			r = (x < 0) ? 16'sd23040 : 16'sd0;
			return r;
		end
		if (x < 0) begin
			base = (y > 0) ? HALF_TURN : -HALF_TURN;
			y = -y;
			x = -x;
		end
		x = x * 256;
		y = y * 256;
		n = (iterations > TABLE_LEN) ? TABLE_LEN : iterations;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + atan_q15[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - atan_q15[i];
			end
		end
		ang = ((acc + 128) >>> 8) + base;
		if (ang > HALF_TURN)
			ang = HALF_TURN;
		if (ang < -HALF_TURN)
			ang = -HALF_TURN;
		r = ang[15:0];
		return r;
	endfunction

	function void note_sample(logic signed [15:0] ay, logic signed [15:0] az);
		roll_want_t w;
		int mag;
		w.accel_y = ay;
		w.accel_z = az;
		w.angle = predict_roll(ay, az);
		mag = (w.angle < 0) ? -int'(w.angle) : int'(w.angle);
		w.alert = (mag > int'(threshold));
		want_q.push_back(w);
		samples++;
	endfunction

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t MISMATCH %s", $realtime, what);
	endfunction

	function void check_result(logic [15:0] angle, logic alert);
		roll_want_t w;
		checked++;
		if (alert === 1'b1)
			alerts_seen++;
		if (want_q.size() == 0) begin
			flag($sformatf("unexpected result angle=%0d alert=%b", $signed(angle), alert));
			return;
		end
		w = want_q.pop_front();
		if (angle !== w.angle)
			flag($sformatf("roll_deg y=%0d z=%0d expected %0d actual %0d",
				w.accel_y, w.accel_z, w.angle, $signed(angle)));
		if (alert !== w.alert)
			flag($sformatf("tilt_alert y=%0d z=%0d angle=%0d thr=%0d expected %b actual %b",
				w.accel_y, w.accel_z, w.angle, threshold, w.alert, alert));
	endfunction
endclass

module accel_roll_tilt_alert_unit_tb;
	localparam int ITERS = 16;
	localparam int LATENCY = ITERS + 3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_CYCLES = 400;
	localparam int PHASE_ITEMS = 200;
	localparam int NUM_DIRECTED = 24;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	roll_scoreboard sb = new(ITERS);
	int threshold_writes;
	bit pressure_done;

	int dir_y [NUM_DIRECTED] = '{
		0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, 32767,
		-32768, 1, -1, 1, -1, 32767, -32768, 100, -100, 12345, 4096, -4096
	};
	int dir_z [NUM_DIRECTED] = '{
		0, 1, -1, -32768, 32767, 0, 0, 0, 0, 32767, -32768, -32768,
		32767, -1, -1, -32768, -32768, -1, 1, 100, 100, -6789, 4096, -4096
	};

	accel_roll_tilt_alert_unit #(
		.ANGLE_ITERATIONS(ITERS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_sample(logic signed [15:0] ay, logic signed [15:0] az, int gap);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {az, ay};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_sample(ay, az);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.want_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4)
			@(posedge clk);
	endtask

	task automatic write_threshold(logic [14:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.threshold = value;
		threshold_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_sample(output logic signed [15:0] ay, output logic signed [15:0] az);
		int r;
		int d;
		r = $urandom_range(0, 9);
		ay = 16'($urandom());
		az = 16'($urandom());
		case (r)
			5: begin
				ay = 16'(int'($urandom_range(0, 128)) - 64);
				az = 16'(int'($urandom_range(0, 128)) - 64);
			end
			6: begin
				if ($urandom_range(0, 1))
					ay = 16'sd0;
				else
					az = 16'sd0;
			end
			7: begin
				d = int'($urandom_range(0, 16)) - 8;
				if ($urandom_range(0, 1))
					ay = 16'(d);
				else
					az = 16'(d);
			end
			8: begin
				ay = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				az = $urandom_range(0, 2) == 0 ? 16'sh7fff :
					($urandom_range(0, 1) ? 16'sh8000 : 16'sh0001);
			end
			9: begin
				d = int'($urandom_range(0, 6)) - 3;
				az = 16'(int'($urandom_range(0, 40000)) - 20000);
				ay = $urandom_range(0, 1) ? 16'(int'(az) + d) : 16'(-int'(az) + d);
			end
			default: begin
			end
		endcase
	endtask

	initial begin
		int gap;
		int r;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!pressure_done && sb.checked >= PRESSURE_AT) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (PRESSURE_CYCLES)
					@(negedge clk);
				pressure_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			@(negedge clk);
			if (r < 3) begin
				m_axis_tready <= 1'b0;
				gap = $urandom_range(20, 80);
			end else if (r < 25) begin
				m_axis_tready <= 1'b0;
				gap = $urandom_range(1, 4);
			end else begin
				m_axis_tready <= 1'b1;
				gap = $urandom_range(1, 30);
			end
			repeat (gap - 1)
				@(negedge clk);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic [14:0] plan [8];
		bit steady;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		plan = '{15'd0, 15'd23040, 15'd16383, 15'd1, 15'd23039, 15'd0, 15'd0, 15'd5760};
		plan[5] = 15'($urandom_range(0, 23040));
		plan[6] = 15'($urandom_range(0, 23040));
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;

		// The threshold is left at its reset value for the directed samples.
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_sample(16'(dir_y[i]), 16'(dir_z[i]), sender_gap());
		drain_pipeline();

		steady = 1'b0;
		foreach (plan[p]) begin
			write_threshold(plan[p]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					steady = ($urandom_range(0, 3) == 0);
				random_sample(ay, az);
				send_sample(ay, az, steady ? 0 : sender_gap());
			end
			drain_pipeline();
		end

		$display("Checked %0d results from %0d samples over %0d threshold settings, %0d alerts.",
			sb.checked, sb.samples, threshold_writes + 1, sb.alerts_seen);
		$display("Output back-pressure hold of %0d cycles applied: %0d.",
			PRESSURE_CYCLES, pressure_done);
		if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.want_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
